// File: rtl/lfw_pkg.sv
// Shared types and constants for the line folder.
// No dependencies; every other design file of the block but lfw_ram imports this package.
package lfw_pkg;

    // Tab stops and column tracking
    localparam int TAB_STOP = 8;
    localparam int TAB_BITS = $clog2(TAB_STOP);
    localparam int COL_W    = 9;

    // Command fields sized for the largest supported line store (4096 bytes)
    localparam int CMD_AW          = 12;
    localparam int CMD_LW          = 13;
    localparam int CMD_QUEUE_DEPTH = 4;

    // Control characters
    localparam logic [7:0] CH_BS  = 8'h08;
    localparam logic [7:0] CH_TAB = 8'h09;
    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_CR  = 8'h0D;
    localparam logic [7:0] CH_SP  = 8'h20;

    // Configuration register indexes
    typedef enum logic [1:0] {
        REG_LINE_WIDTH   = 2'd0,
        REG_COUNT_BYTES  = 2'd1,
        REG_BREAK_BLANKS = 2'd2
    } t_reg_idx;

    typedef struct packed {
        logic [COL_W-1:0] line_width;
        logic             count_bytes;
        logic             break_at_blanks;
    } t_cfg;

    localparam t_cfg CFG_RESET = '{line_width: 9'd80, count_bytes: 1'b0, break_at_blanks: 1'b0};

    // Emit command: a run of stored bytes, optionally followed by a newline,
    // or the end marker of one request.
    typedef struct packed {
        logic [CMD_LW-1:0] len;
        logic [CMD_AW-1:0] addr;
        logic              nl;
        logic              ovf;
        logic              is_end;
    } t_cmd;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_STEP,
        FR_WRITE,
        FR_END
    } t_fr_state;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_READ,
        BK_PUT,
        BK_NL,
        BK_END
    } t_bk_state;

    // Column after one byte; one bit wider than the column to catch overrun
    function automatic logic [COL_W:0] next_col(input logic [COL_W-1:0] col,
                                                input logic [7:0]       b,
                                                input logic             cb);
        logic [COL_W:0] c;
        c = {1'b0, col};
        if (cb) begin
            return c + 1'b1;
        end
        unique case (b)
            CH_BS:   return (col != '0) ? c - 1'b1 : '0;
            CH_CR:   return '0;
            CH_TAB:  return {c[COL_W:TAB_BITS] + 1'b1, {TAB_BITS{1'b0}}};
            default: return c + 1'b1;
        endcase
    endfunction

    function automatic logic is_blank(input logic [7:0] b);
        return (b == CH_SP) || (b == CH_TAB);
    endfunction

endpackage

// File: rtl/lfw_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module lfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/lfw_cmd_fifo.sv
// Short command queue between the front and back parts of the line folder.
// Depends on lfw_pkg for the command type.
module lfw_cmd_fifo import lfw_pkg::*; #(
    parameter int DEPTH = 4
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    localparam int PW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    t_cmd          r_mem [DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_count;

    function automatic logic [PW-1:0] ptr_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    // Pointers and fill level
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_full  = r_count == CW'(DEPTH);
    assign o_empty = r_count == '0;

    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command pushed into a full queue");

    a_no_underrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command popped from an empty queue");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue fill level out of range");

endmodule

// File: rtl/lfw_front.sv
// Front part: accepts bytes, tracks column and line state, decides breaks
// and queues emit commands. Writes the line store. Depends on lfw_pkg.
module lfw_front import lfw_pkg::*; #(
    parameter int LINE_MAX = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [7:0]                  i_text_byte,
    input  logic                        i_end_of_input,
    input  t_cfg                        i_cfg,
    output logic                        o_cmd_push,
    output t_cmd                        o_cmd,
    input  logic                        i_cmd_full,
    input  logic                        i_drained,
    output logic                        o_ram_we,
    output logic [$clog2(LINE_MAX)-1:0] o_ram_waddr,
    output logic [7:0]                  o_ram_wdata
);

    localparam int AW = $clog2(LINE_MAX);
    localparam int FW = $clog2(LINE_MAX + 1);
    localparam int TW = (FW > COL_W) ? FW : COL_W;
    localparam logic [AW:0] LM = (AW + 1)'(LINE_MAX);

    t_fr_state        r_state, n_state;
    logic [7:0]       r_byte;
    logic             r_eoi;
    logic             r_emitted;
    logic [AW-1:0]    r_head;
    logic [FW-1:0]    r_fill;
    logic [COL_W-1:0] r_col;
    logic [FW-1:0]    r_cut;   // one past the last blank, 0 if none
    logic [TW-1:0]    r_tail;  // display column of the bytes after the last blank

    logic [COL_W:0] nc;
    logic           fits, store_full, is_nl;
    logic           dec_hold, dec_blank, dec_full;
    logic           need_push, step_go;

    // Circular store address
    function automatic logic [AW-1:0] wrap(input logic [AW-1:0] base,
                                           input logic [FW-1:0] off);
        logic [AW:0] s;
        s = (AW + 1)'(base) + (AW + 1)'(off);
        if (s >= LM) begin
            s = s - LM;
        end
        return s[AW-1:0];
    endfunction

    // Column step for non-blank bytes in display mode
    function automatic logic [TW-1:0] tail_step(input logic [TW-1:0] t,
                                                input logic [7:0]    b);
        unique case (b)
            CH_BS:   return (t != '0) ? t - 1'b1 : '0;
            CH_CR:   return '0;
            default: return t + 1'b1;
        endcase
    endfunction

    // Classify the held byte
    assign nc         = next_col(r_col, r_byte, i_cfg.count_bytes);
    assign fits       = nc <= {1'b0, i_cfg.line_width};
    assign store_full = r_fill == FW'(LINE_MAX);
    assign is_nl      = !r_eoi && (r_byte == CH_NL);
    assign dec_hold   = !r_eoi && !is_nl && (fits || r_fill == '0);
    assign dec_blank  = !r_eoi && !is_nl && !dec_hold && i_cfg.break_at_blanks
                        && (r_cut != '0);
    assign dec_full   = !r_eoi && !is_nl && !dec_hold && !dec_blank;
    assign need_push  = (r_eoi && r_fill != '0) || is_nl || (dec_hold && store_full)
                        || dec_blank || dec_full;
    assign step_go    = !need_push || !i_cmd_full;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            FR_IDLE: begin
                if (i_valid) begin
                    n_state = FR_STEP;
                end
            end
            FR_STEP: begin
                if (step_go) begin
                    if (r_eoi) begin
                        n_state = (r_fill != '0) ? FR_END : FR_IDLE;
                    end else if (is_nl) begin
                        n_state = FR_END;
                    end else if (dec_hold) begin
                        n_state = FR_WRITE;
                    end
                end
            end
            FR_WRITE: begin
                if (i_drained) begin
                    n_state = r_emitted ? FR_END : FR_IDLE;
                end
            end
            FR_END: begin
                if (!i_cmd_full) begin
                    n_state = FR_IDLE;
                end
            end
            default: n_state = FR_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_stall    = r_state != FR_IDLE;
        o_cmd_push = 1'b0;
        o_cmd      = '0;
        o_ram_we   = 1'b0;
        unique case (r_state)
            FR_STEP: begin
                o_cmd_push = need_push && !i_cmd_full;
                o_cmd.addr = CMD_AW'(r_head);
                if (dec_blank) begin
                    o_cmd.len = CMD_LW'(r_cut);
                end else if (dec_hold) begin
                    o_cmd.len = CMD_LW'(LINE_MAX);
                end else begin
                    o_cmd.len = CMD_LW'(r_fill);
                end
                o_cmd.nl  = is_nl || dec_blank || dec_full;
                o_cmd.ovf = dec_hold;
            end
            FR_WRITE: o_ram_we = i_drained;
            FR_END: begin
                o_cmd_push   = !i_cmd_full;
                o_cmd.is_end = 1'b1;
            end
            default: ;
        endcase
    end

    assign o_ram_waddr = wrap(r_head, r_fill);
    assign o_ram_wdata = r_byte;

    // Line state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= FR_IDLE;
            r_emitted <= 1'b0;
            r_head    <= '0;
            r_fill    <= '0;
            r_col     <= '0;
            r_cut     <= '0;
            r_tail    <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                FR_IDLE: begin
                    if (i_valid) begin
                        r_emitted <= 1'b0;
                    end
                end
                FR_STEP: begin
                    if (step_go) begin
                        if (dec_hold) begin
                            r_col <= nc[COL_W-1:0];
                            if (store_full) begin
                                // overflow: store sent as is, column kept
                                r_fill    <= '0;
                                r_cut     <= '0;
                                r_tail    <= '0;
                                r_emitted <= 1'b1;
                            end
                        end else if (dec_blank) begin
                            r_head    <= wrap(r_head, r_cut);
                            r_fill    <= r_fill - r_cut;
                            r_col     <= i_cfg.count_bytes ? COL_W'(r_fill - r_cut)
                                                           : COL_W'(r_tail);
                            r_cut     <= '0;
                            r_emitted <= 1'b1;
                        end else begin
                            // end of input, newline or plain break
                            r_head    <= wrap(r_head, r_fill);
                            r_fill    <= '0;
                            r_col     <= '0;
                            r_cut     <= '0;
                            r_tail    <= '0;
                            r_emitted <= 1'b1;
                        end
                    end
                end
                FR_WRITE: begin
                    if (i_drained) begin
                        r_fill <= r_fill + 1'b1;
                        if (is_blank(r_byte)) begin
                            r_cut  <= r_fill + 1'b1;
                            r_tail <= '0;
                        end else begin
                            r_tail <= tail_step(r_tail, r_byte);
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // Request capture
    always_ff @(posedge i_clk) begin
        if (r_state == FR_IDLE && i_valid) begin
            r_byte <= i_text_byte;
            r_eoi  <= i_end_of_input;
        end
    end

    a_fill_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= FW'(LINE_MAX))
        else $error("fill count beyond line store");

    a_cut_in_line: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cut <= r_fill)
        else $error("blank position past end of line");

    a_write_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_ram_we |-> i_drained)
        else $error("store written while back part still reads");

endmodule

// File: rtl/lfw_back.sv
// Back part: carries out emit commands, reads the line store and packs
// bytes into chunks of up to eight. Depends on lfw_pkg.
module lfw_back import lfw_pkg::*; #(
    parameter int LINE_MAX = 256
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_valid,
    output logic                        o_cmd_pop,
    input  t_cmd                        i_cmd,
    output logic                        o_ram_re,
    output logic [$clog2(LINE_MAX)-1:0] o_ram_raddr,
    input  logic [7:0]                  i_ram_rdata,
    output logic                        o_idle,
    output logic                        o_valid,
    input  logic                        i_stall,
    output logic [63:0]                 o_out_chunk,
    output logic [3:0]                  o_chunk_count,
    output logic                        o_store_overflow,
    output logic                        o_last_chunk
);

    localparam int AW = $clog2(LINE_MAX);
    localparam int FW = $clog2(LINE_MAX + 1);

    t_bk_state     r_state, n_state;
    logic [AW-1:0] r_addr;
    logic [FW-1:0] r_left;
    logic          r_nl;
    logic          r_ovf;
    logic [63:0]   r_acc;
    logic [3:0]    r_cnt;
    logic          r_out_valid;
    logic [63:0]   r_out_chunk;
    logic [3:0]    r_out_count;
    logic          r_out_ovf;
    logic          r_out_last;

    logic       out_free, app_req, app_fire, end_fire, load_out;
    logic [7:0] app_byte;

    // Chunk assembly handshake
    assign out_free = !r_out_valid || !i_stall;
    assign app_req  = (r_state == BK_PUT) || (r_state == BK_NL);
    assign app_byte = (r_state == BK_NL) ? CH_NL : i_ram_rdata;
    assign app_fire = app_req && ((r_cnt != 4'd8) || out_free);
    assign end_fire = (r_state == BK_END) && ((r_cnt == '0) || out_free);
    assign load_out = (app_fire && r_cnt == 4'd8) || (end_fire && r_cnt != '0);

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: begin
                if (i_cmd_valid) begin
                    if (i_cmd.is_end) begin
                        n_state = BK_END;
                    end else if (i_cmd.len != '0) begin
                        n_state = BK_READ;
                    end else if (i_cmd.nl) begin
                        n_state = BK_NL;
                    end
                end
            end
            BK_READ: n_state = BK_PUT;
            BK_PUT: begin
                if (app_fire) begin
                    if (r_left == FW'(1)) begin
                        n_state = r_nl ? BK_NL : BK_IDLE;
                    end else begin
                        n_state = BK_READ;
                    end
                end
            end
            BK_NL: begin
                if (app_fire) begin
                    n_state = BK_IDLE;
                end
            end
            BK_END: begin
                if (end_fire) begin
                    n_state = BK_IDLE;
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    // Outputs
    always_comb begin
        o_cmd_pop   = (r_state == BK_IDLE) && i_cmd_valid;
        o_ram_re    = r_state == BK_READ;
        o_ram_raddr = r_addr;
        o_idle      = r_state == BK_IDLE;
    end

    // Sequencer and chunk accumulator
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_acc       <= '0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (app_fire) begin
                if (r_cnt == 4'd8) begin
                    r_acc <= {56'd0, app_byte};
                    r_cnt <= 4'd1;
                end else begin
                    r_acc[{r_cnt[2:0], 3'b000} +: 8] <= app_byte;
                    r_cnt <= r_cnt + 1'b1;
                end
            end else if (end_fire) begin
                r_acc <= '0;
                r_cnt <= '0;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Command fields and output payload
    always_ff @(posedge i_clk) begin
        if (o_cmd_pop && !i_cmd.is_end) begin
            r_addr <= i_cmd.addr[AW-1:0];
            r_left <= i_cmd.len[FW-1:0];
            r_nl   <= i_cmd.nl;
            r_ovf  <= i_cmd.ovf;
        end else if (r_state == BK_PUT && app_fire) begin
            r_addr <= (r_addr == AW'(LINE_MAX - 1)) ? '0 : r_addr + 1'b1;
            r_left <= r_left - 1'b1;
        end
        if (load_out) begin
            r_out_chunk <= r_acc;
            r_out_count <= r_cnt;
            r_out_ovf   <= r_ovf;
            r_out_last  <= end_fire;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_out_chunk      = r_out_chunk;
    assign o_chunk_count    = r_out_count;
    assign o_store_overflow = r_out_ovf;
    assign o_last_chunk     = r_out_last;

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= 4'd8)
        else $error("chunk byte count beyond eight");

    a_inner_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_count == 4'd8))
        else $error("chunk other than the last is not full");

    a_out_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_count != '0))
        else $error("empty chunk presented");

endmodule

// File: rtl/line_fold_wrapper_top.sv
// Line folder: takes one text byte (or an end-of-input marker) per request
// and emits the folded text as chunks of up to eight bytes, the last chunk
// of each request flagged. A byte that goes into the line store first waits
// until all earlier commands have been carried out by the back part. The
// store is read through one RAM port, with a read step and a put step for
// each byte emitted, and the output stall can hold the reads. The line store
// needs no clearing after reset. Depends on lfw_pkg, lfw_front, lfw_cmd_fifo,
// lfw_back and lfw_ram.
module line_fold_wrapper_top import lfw_pkg::*; #(
    parameter int LINE_MAX = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_text_byte,
    input  logic        i_end_of_input,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [63:0] o_out_chunk,
    output logic [3:0]  o_chunk_count,
    output logic        o_store_overflow,
    output logic        o_last_chunk,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [8:0]  i_cfg_data
);

    localparam int AW = $clog2(LINE_MAX);

    t_cfg          r_cfg;
    logic          cmd_push, cmd_full, cmd_pop, cmd_empty;
    t_cmd          cmd_in, cmd_out;
    logic          back_idle, drained;
    logic          ram_we, ram_re;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [7:0]    ram_wdata, ram_rdata;

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= CFG_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LINE_WIDTH:   r_cfg.line_width      <= i_cfg_data;
                REG_COUNT_BYTES:  r_cfg.count_bytes     <= i_cfg_data[0];
                REG_BREAK_BLANKS: r_cfg.break_at_blanks <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // Store may be rewritten only when no command is pending
    assign drained = cmd_empty && back_idle;

    lfw_front #(.LINE_MAX(LINE_MAX)) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_in_valid),
        .o_stall        (o_in_stall),
        .i_text_byte    (i_text_byte),
        .i_end_of_input (i_end_of_input),
        .i_cfg          (r_cfg),
        .o_cmd_push     (cmd_push),
        .o_cmd          (cmd_in),
        .i_cmd_full     (cmd_full),
        .i_drained      (drained),
        .o_ram_we       (ram_we),
        .o_ram_waddr    (ram_waddr),
        .o_ram_wdata    (ram_wdata)
    );

    lfw_cmd_fifo #(.DEPTH(CMD_QUEUE_DEPTH)) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (cmd_full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty)
    );

    lfw_ram #(.WIDTH(8), .DEPTH(LINE_MAX)) u_line_store (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    lfw_back #(.LINE_MAX(LINE_MAX)) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (!cmd_empty),
        .o_cmd_pop        (cmd_pop),
        .i_cmd            (cmd_out),
        .o_ram_re         (ram_re),
        .o_ram_raddr      (ram_raddr),
        .i_ram_rdata      (ram_rdata),
        .o_idle           (back_idle),
        .o_valid          (o_out_valid),
        .i_stall          (i_out_stall),
        .o_out_chunk      (o_out_chunk),
        .o_chunk_count    (o_chunk_count),
        .o_store_overflow (o_store_overflow),
        .o_last_chunk     (o_last_chunk)
    );

endmodule

// File: tb/line_fold_wrapper_top_tb.sv
// Testbench for line_fold_wrapper_top: directed and random text streams under several
// width and mode settings, checked chunk by chunk against a line-folding predictor.
// Depends on lfw_pkg and the line_fold_wrapper_top RTL.
module line_fold_wrapper_top_tb;
    import lfw_pkg::*;

    localparam int STORE_DEPTH = 256;
    localparam int OUT_CAP     = STORE_DEPTH + 16;
    localparam int SETTLE_CYC  = 700;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int LONG_HOLD   = 400;
    localparam logic [1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic [63:0] chunk;
        logic [3:0]  count;
        logic        ovf;
        logic        last;
    } t_chunk;

    // Folding predictor plus the queue of chunks still to come
    class fold_scoreboard;
        logic [7:0]  line_q [STORE_DEPTH];
        int unsigned fill;
        int unsigned col;
        int unsigned width;
        bit          cb;
        bit          bb;
        logic [7:0]  obuf [$];
        t_chunk      chunks_due [$];
        int          errors;

        function new();
            width = 80; cb = 0; bb = 0; fill = 0; col = 0; errors = 0;
        endfunction

        function void set_reg(logic [1:0] idx, logic [8:0] data);
            case (idx)
                REG_LINE_WIDTH:   width = data;
                REG_COUNT_BYTES:  cb = data[0];
                REG_BREAK_BLANKS: bb = data[0];
                default: ;
            endcase
        endfunction

        function int unsigned step_col(int unsigned c, logic [7:0] b);
            if (cb) return c + 1;
            case (b)
                CH_BS:   return (c > 0) ? c - 1 : 0;
                CH_CR:   return 0;
                CH_TAB:  return c + TAB_STOP - (c % TAB_STOP);
                default: return c + 1;
            endcase
        endfunction

        function void put_byte(logic [7:0] b);
            if (obuf.size() < OUT_CAP) obuf.push_back(b);
        endfunction

        function void put_line(int unsigned n);
            for (int unsigned i = 0; i < n && i < STORE_DEPTH; i++) put_byte(line_q[i]);
        endfunction

        function bit hold(logic [7:0] b);
            bit ovf;
            ovf = 0;
            if (fill >= STORE_DEPTH) begin
                put_line(STORE_DEPTH);
                fill = 0;
                ovf = 1;
            end
            line_q[fill] = b;
            fill++;
            return ovf;
        endfunction

        function bit fold_byte(logic [7:0] b);
            int unsigned nc, cut;
            if (b == CH_NL) begin
                put_line(fill);
                put_byte(CH_NL);
                fill = 0;
                col = 0;
                return 0;
            end
            forever begin
                nc = step_col(col, b);
                if (nc <= width || fill == 0) begin
                    col = nc & 9'h1FF;
                    return hold(b);
                end
                cut = 0;
                if (bb) begin
                    for (int unsigned i = fill; i > 0; i--) begin
                        if (is_blank(line_q[i-1])) begin
                            cut = i;
                            break;
                        end
                    end
                end
                if (cut > 0) begin
                    // break after the last blank, carry the rest over
                    put_line(cut);
                    put_byte(CH_NL);
                    for (int unsigned i = 0; i < fill - cut; i++) line_q[i] = line_q[i+cut];
                    fill -= cut;
                    col = 0;
                    for (int unsigned i = 0; i < fill; i++) col = step_col(col, line_q[i]);
                    col &= 9'h1FF;
                end else begin
                    put_line(fill);
                    put_byte(CH_NL);
                    fill = 0;
                    col = 0;
                end
            end
        endfunction

        // Note one accepted request and queue the chunks it causes
        function void note_input(logic [7:0] b, logic eoi);
            bit     ovf;
            int     n;
            t_chunk c;
            ovf = 0;
            obuf.delete();
            if (eoi) begin
                put_line(fill);
                fill = 0;
                col = 0;
            end else begin
                ovf = fold_byte(b);
            end
            for (int pos = 0; pos < obuf.size(); pos += 8) begin
                n = obuf.size() - pos;
                if (n > 8) n = 8;
                c = '0;
                for (int j = 0; j < n; j++) c.chunk[8*j +: 8] = obuf[pos+j];
                c.count = 4'(n);
                c.ovf   = ovf;
                c.last  = (pos + n >= obuf.size());
                chunks_due.push_back(c);
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %h expected %h", what, got, want);
            errors++;
        endtask

        task check_result(t_chunk got);
            t_chunk want;
            if (chunks_due.size() == 0) begin
                report("unexpected chunk", got.chunk, 64'd0);
                return;
            end
            want = chunks_due.pop_front();
            if (got.chunk !== want.chunk) report("out_chunk", got.chunk, want.chunk);
            if (got.count !== want.count) report("chunk_count", got.count, want.count);
            if (got.ovf !== want.ovf)     report("store_overflow", got.ovf, want.ovf);
            if (got.last !== want.last)   report("last_chunk", got.last, want.last);
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_text_byte;
    logic        i_end_of_input;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [63:0] o_out_chunk;
    logic [3:0]  o_chunk_count;
    logic        o_store_overflow;
    logic        o_last_chunk;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [1:0]  i_cfg_index;
    logic [8:0]  i_cfg_data;

    fold_scoreboard sb;
    bit             no_idle;
    bit             hold_req;
    int             cycles;

    line_fold_wrapper_top dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int draw_wait();
        if (no_idle) return 0;
        return $urandom_range(0, 15);
    endfunction

    // Cycle limit
    initial begin
        cycles = 0;
        forever begin
            @(posedge i_clk);
            cycles++;
            if (cycles >= CYCLE_LIMIT) begin
                $display("line_fold_wrapper_top_tb: done, errors");
                $finish;
            end
        end
    end

    // Result side: random stalls, one long hold-off on request
    initial begin : result_side
        int d;
        i_out_stall = 1'b1;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            d = draw_wait();
            if (hold_req) begin
                d += LONG_HOLD;
                hold_req = 0;
            end
            if (d > 0) begin
                i_out_stall <= 1'b1;
                repeat (d) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
            sb.check_result('{o_out_chunk, o_chunk_count, o_store_overflow, o_last_chunk});
        end
    end

    task automatic send_req(logic [7:0] b, logic eoi);
        int gap;
        gap = draw_wait();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_text_byte    <= b;
        i_end_of_input <= eoi;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_input(b, eoi);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [8:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_reg(idx, data);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Drain all output, then let a request with no output finish
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.chunks_due.size() > 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic setup(logic [8:0] w, bit c, bit b);
        settle();
        write_reg(REG_LINE_WIDTH, w);
        write_reg(REG_COUNT_BYTES, {8'($urandom_range(0, 255)), c});
        write_reg(REG_BREAK_BLANKS, {8'($urandom_range(0, 255)), b});
    endtask

    task automatic send_text(logic [7:0] s []);
        foreach (s[i]) send_req(s[i], 1'b0);
    endtask

    // Random text: mostly words and blanks, some controls and noise
    task automatic random_text(int n);
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            if (r < 55)      send_req(8'(8'h61 + $urandom_range(0, 25)), 1'b0);
            else if (r < 72) send_req(CH_SP, 1'b0);
            else if (r < 76) send_req(CH_TAB, 1'b0);
            else if (r < 78) send_req(CH_BS, 1'b0);
            else if (r < 80) send_req(CH_CR, 1'b0);
            else if (r < 86) send_req(CH_NL, 1'b0);
            else if (r < 89) send_req(8'($urandom_range(0, 255)), 1'b1);
            else             send_req(8'($urandom_range(0, 255)), 1'b0);
        end
    endtask

    task automatic letters(int n);
        repeat (n) send_req(8'(8'h41 + $urandom_range(0, 25)), 1'b0);
    endtask

    initial begin
        sb = new();
        no_idle = 0;
        hold_req = 0;
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_text_byte = '0;
        i_end_of_input = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset settings: plain bytes, byte extremes, every control, end marker
        send_text('{8'h61, 8'h00, 8'hFF, CH_SP, CH_TAB, CH_BS, CH_CR, CH_NL});
        send_req(8'hFF, 1'b1);
        // Width 1, hard breaks; a tab wider than the line stands alone
        setup(9'd1, 0, 0);
        send_text('{8'h61, 8'h62, CH_TAB, CH_NL});
        // Width 0: each advancing byte alone; a backspace back to column 0
        setup(9'd0, 0, 1);
        send_text('{8'h78, 8'h79, CH_BS, CH_TAB});
        send_req(8'h00, 1'b1);
        // Break after the last blank
        setup(9'd8, 0, 1);
        send_text('{8'h61, 8'h62, CH_SP, 8'h63, 8'h64, 8'h65, 8'h66, 8'h67, 8'h68});
        send_req(8'h55, 1'b1);
        // Ignored register index
        settle();
        write_reg(REG_SPARE, 9'($urandom_range(0, 511)));

        // Random phases across settings; the long hold-off in one of them
        setup(9'd10, 0, 1);  random_text(25);
        setup(9'd256, 0, 0); random_text(25);
        no_idle = 1;
        hold_req = 1;
        setup(9'd1, 0, 1);   random_text(35);
        no_idle = 0;
        setup(9'd511, 1, 1); random_text(25);
        setup(9'd20, 1, 0);  random_text(25);
        no_idle = 1;
        setup(9'd0, 0, 1);   random_text(20);
        no_idle = 0;
        setup(9'd33, 0, 0);  random_text(25);

        // Full store: an overflowing byte, then flush the remainder
        setup(9'd511, 1, 0);
        send_req(8'h00, 1'b1);
        letters(STORE_DEPTH + 1);
        send_req(8'hA5, 1'b1);

        settle();
        if (sb.errors == 0 && sb.chunks_due.size() == 0) begin
            $display("line_fold_wrapper_top_tb: done, clean");
        end else begin
            $display("line_fold_wrapper_top_tb: done, errors");
        end
        $finish;
    end
endmodule
